// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SRCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SRCA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/srca_pkg.sv -----
// ----------------------------------------------------------------------------
// srca_pkg
// Field widths, result codes, queued request type and sequence arithmetic.
// ----------------------------------------------------------------------------
package srca_pkg;

	localparam int SEQ_W    = 31;
	localparam int LEN_W    = 11;
	localparam int HANDLE_W = 16;
	localparam int STAMP_W  = 32;
	localparam int KIND_W   = 2;

	localparam logic [KIND_W-1:0] KIND_REL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END = 2'd2;

	localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

	typedef enum logic [1:0] {
		CLS_SEG = 2'd0,
		CLS_END = 2'd1,
		CLS_BAD = 2'd2
	} item_cls_t;

	typedef struct packed {
		logic [SEQ_W-1:0]    seq;
		logic [LEN_W-1:0]    len;
		logic [HANDLE_W-1:0] handle;
		logic [STAMP_W-1:0]  stamp;
		item_cls_t           cls;
	} item_t;

	// Saturating seq + len.
	function automatic logic [SEQ_W-1:0] advance(input logic [SEQ_W-1:0] seq,
		input logic [LEN_W-1:0] len);
		logic [SEQ_W:0] sum;
		sum = {1'b0, seq} + {{(SEQ_W+1-LEN_W){1'b0}}, len};
		return sum[SEQ_W] ? SEQ_MAX : sum[SEQ_W-1:0];
	endfunction

endpackage

// ----- rtl/core/srca_ram.sv -----
// ----------------------------------------------------------------------------
// srca_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/core/srca_front.sv -----
// ----------------------------------------------------------------------------
// srca_front
// Accept requests, classify them, and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module srca_front #(
	parameter int MAX_SEGMENT_BYTES = 1456
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [srca_pkg::SEQ_W-1:0]    seq_number,
	input  logic [srca_pkg::LEN_W-1:0]    data_length,
	input  logic [srca_pkg::HANDLE_W-1:0] payload_handle,
	input  logic [srca_pkg::STAMP_W-1:0]  tx_stamp,
	output logic                          q_valid,
	output srca_pkg::item_t               q_item,
	input  logic                          q_pop
);
	srca_pkg::item_t fifo_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;
	logic            done_q;
	logic            take, push;
	srca_pkg::item_t item;

	assign busy    = (count_q == 2'd2);
	assign take    = start && !busy;
	assign push    = take && !done_q;
	assign q_valid = (count_q != 2'd0);
	assign q_item  = fifo_q[rd_ptr_q];

	always_comb begin
		item.seq    = seq_number;
		item.len    = data_length;
		item.handle = payload_handle;
		item.stamp  = tx_stamp;
		if (data_length == '0) begin
			item.cls = srca_pkg::CLS_END;
		end else if (data_length > srca_pkg::LEN_W'(MAX_SEGMENT_BYTES)) begin
			item.cls = srca_pkg::CLS_BAD;
		end else begin
			item.cls = srca_pkg::CLS_SEG;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			done_q   <= 1'b0;
		end else begin
			// drop everything after end of stream
			if (push && data_length == '0) begin
				done_q <= 1'b1;
			end
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end
endmodule

// ----- rtl/core/srca_back.sv -----
// ----------------------------------------------------------------------------
// srca_back
// Park, release and acknowledge segments; drive the result registers.
// ----------------------------------------------------------------------------
module srca_back #(
	parameter int SLOTS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  srca_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          strobe,
	output logic [srca_pkg::KIND_W-1:0]   result_kind,
	output logic [srca_pkg::SEQ_W-1:0]    position,
	output logic [srca_pkg::LEN_W-1:0]    released_length,
	output logic [srca_pkg::HANDLE_W-1:0] released_handle,
	output logic [srca_pkg::STAMP_W-1:0]  echo_stamp,
	output logic                          last_of_run
);
	localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int RAM_W = srca_pkg::LEN_W + srca_pkg::HANDLE_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CLASS = 4'b0010,
		ST_MATCH = 4'b0100,
		ST_READ  = 4'b1000
	} state_t;

	state_t                      state_q;
	srca_pkg::item_t             cur_q;
	logic [srca_pkg::SEQ_W-1:0]  expected_q;
	logic [SLOTS-1:0]            valid_q;
	logic [srca_pkg::SEQ_W-1:0]  slot_seq_q [SLOTS];
	logic [IDX_W-1:0]            hit_idx_q;

	logic                        dup, has_free, has_match;
	logic [IDX_W-1:0]            free_idx, match_idx;
	logic                        ram_we;
	logic [RAM_W-1:0]            ram_rdata;
	logic [srca_pkg::LEN_W-1:0]  rd_len;
	logic [srca_pkg::HANDLE_W-1:0] rd_handle;

	// parallel compare across all slots
	always_comb begin
		dup       = 1'b0;
		has_free  = 1'b0;
		has_match = 1'b0;
		free_idx  = '0;
		match_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && slot_seq_q[i] == cur_q.seq) begin
				dup = 1'b1;
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = IDX_W'(i);
			end
			if (valid_q[i] && slot_seq_q[i] == expected_q) begin
				has_match = 1'b1;
				match_idx = IDX_W'(i);
			end
		end
	end

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign ram_we = (state_q == ST_CLASS) && (cur_q.cls == srca_pkg::CLS_SEG)
		&& (cur_q.seq > expected_q) && !dup && has_free;
	assign {rd_len, rd_handle} = ram_rdata;

	srca_ram #(.WIDTH(RAM_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata ({cur_q.len, cur_q.handle}),
		.raddr (match_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (ram_we) begin
			slot_seq_q[free_idx] <= cur_q.seq;
		end
		if (state_q == ST_MATCH) begin
			hit_idx_q <= match_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			expected_q      <= '0;
			valid_q         <= '0;
			strobe          <= 1'b0;
			result_kind     <= srca_pkg::KIND_REL;
			position        <= '0;
			released_length <= '0;
			released_handle <= '0;
			echo_stamp      <= '0;
			last_of_run     <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[free_idx] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					strobe <= 1'b0;
					if (q_valid) begin
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					strobe <= 1'b1;
					if (cur_q.cls == srca_pkg::CLS_END) begin
						result_kind     <= srca_pkg::KIND_END;
						position        <= expected_q;
						released_length <= '0;
						released_handle <= '0;
						echo_stamp      <= '0;
						last_of_run     <= 1'b1;
						state_q         <= ST_IDLE;
					end else if (cur_q.cls == srca_pkg::CLS_SEG
						&& cur_q.seq == expected_q) begin
						result_kind     <= srca_pkg::KIND_REL;
						position        <= cur_q.seq;
						released_length <= cur_q.len;
						released_handle <= cur_q.handle;
						echo_stamp      <= '0;
						last_of_run     <= 1'b0;
						expected_q      <= srca_pkg::advance(cur_q.seq, cur_q.len);
						state_q         <= ST_MATCH;
					end else begin
						result_kind     <= srca_pkg::KIND_ACK;
						position        <= expected_q;
						released_length <= '0;
						released_handle <= '0;
						echo_stamp      <= cur_q.stamp;
						last_of_run     <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				ST_MATCH: begin
					if (has_match) begin
						strobe  <= 1'b0;
						state_q <= ST_READ;
					end else begin
						strobe          <= 1'b1;
						result_kind     <= srca_pkg::KIND_ACK;
						position        <= expected_q;
						released_length <= '0;
						released_handle <= '0;
						echo_stamp      <= cur_q.stamp;
						last_of_run     <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				ST_READ: begin
					// matched slot seq equals expected_q
					strobe             <= 1'b1;
					result_kind        <= srca_pkg::KIND_REL;
					position           <= expected_q;
					released_length    <= rd_len;
					released_handle    <= rd_handle;
					echo_stamp         <= '0;
					last_of_run        <= 1'b0;
					expected_q         <= srca_pkg::advance(expected_q, rd_len);
					valid_q[hit_idx_q] <= 1'b0;
					state_q            <= ST_MATCH;
				end
				default: begin
					strobe  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- rtl/core/segment_reorder_cumulative_ack_core.sv -----
// ----------------------------------------------------------------------------
// segment_reorder_cumulative_ack_core
// Receive reorder buffer with in-order release and cumulative ack.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/busy: a segment descriptor is taken at a rising
//   edge with start high and busy low. busy rises only when the two-entry
//   request queue is full.
//   Results leave on strobe, at most one per cycle, each valid for exactly
//   one cycle; the receiver cannot stall them. A request yields zero or
//   more released segments and then one ack (or a single end-of-stream
//   result); last_of_run marks its final result. Requests after end of
//   stream are taken and dropped without result.
//   The back end takes the next queued request only after the final result
//   of the previous one is registered; each buffered segment released by
//   the chain needs a slot compare, then the registered read of the
//   length/handle RAM.
//   Reset: arst_n clears the expected sequence, the end-of-stream flag, all
//   slot valid bits and the queue. Slot contents need no clearing.
// ----------------------------------------------------------------------------
module segment_reorder_cumulative_ack_core #(
	parameter int BUFFER_SLOTS      = 32,
	parameter int MAX_SEGMENT_BYTES = 1456
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [srca_pkg::SEQ_W-1:0]    seq_number,
	input  logic [srca_pkg::LEN_W-1:0]    data_length,
	input  logic [srca_pkg::HANDLE_W-1:0] payload_handle,
	input  logic [srca_pkg::STAMP_W-1:0]  tx_stamp,
	output logic                          strobe,
	output logic [srca_pkg::KIND_W-1:0]   result_kind,
	output logic [srca_pkg::SEQ_W-1:0]    position,
	output logic [srca_pkg::LEN_W-1:0]    released_length,
	output logic [srca_pkg::HANDLE_W-1:0] released_handle,
	output logic [srca_pkg::STAMP_W-1:0]  echo_stamp,
	output logic                          last_of_run
);
	logic            q_valid, q_pop;
	srca_pkg::item_t q_item;

	// front: classify and queue requests
	srca_front #(.MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.seq_number     (seq_number),
		.data_length    (data_length),
		.payload_handle (payload_handle),
		.tx_stamp       (tx_stamp),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	// back: park, chain-release and ack
	srca_back #(.SLOTS(BUFFER_SLOTS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.strobe          (strobe),
		.result_kind     (result_kind),
		.position        (position),
		.released_length (released_length),
		.released_handle (released_handle),
		.echo_stamp      (echo_stamp),
		.last_of_run     (last_of_run)
	);
endmodule

// ----- rtl/core/srca_checker.sv -----
// ----------------------------------------------------------------------------
// srca_checker
// Port-level checks on the result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srca_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          strobe,
	input logic [srca_pkg::KIND_W-1:0]   result_kind,
	input logic [srca_pkg::LEN_W-1:0]    released_length,
	input logic [srca_pkg::HANDLE_W-1:0] released_handle,
	input logic [srca_pkg::STAMP_W-1:0]  echo_stamp,
	input logic                          last_of_run
);
	`SRCA_ASSERT_IMP(a_end_last, clk, arst_n,
		strobe && result_kind == srca_pkg::KIND_END,
		last_of_run && echo_stamp == '0)
	`SRCA_ASSERT_IMP(a_rel_not_last, clk, arst_n,
		strobe && result_kind == srca_pkg::KIND_REL,
		!last_of_run && echo_stamp == '0)
	`SRCA_ASSERT_IMP(a_ack_clean, clk, arst_n,
		strobe && result_kind == srca_pkg::KIND_ACK,
		last_of_run && released_length == '0 && released_handle == '0)
	`SRCA_ASSERT_NXT(a_end_quiet, clk, arst_n,
		strobe && result_kind == srca_pkg::KIND_END, !strobe)
	`SRCA_ASSERT_IMP(a_kind_legal, clk, arst_n, strobe,
		result_kind == srca_pkg::KIND_REL || result_kind == srca_pkg::KIND_ACK
		|| result_kind == srca_pkg::KIND_END)
endmodule

bind segment_reorder_cumulative_ack_core srca_checker u_srca_checker (.*);

// ----- verif/segment_reorder_cumulative_ack_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_reorder_cumulative_ack_core_tb
// Self-checking bench for the receive reorder buffer: a directed table, then
// shuffled bursts with retransmission and noise, checked by a reorder predictor.
// ----------------------------------------------------------------------------
module segment_reorder_cumulative_ack_core_tb;

	localparam int NUM_SLOTS   = 32;
	localparam int MAX_BYTES   = 1456;
	localparam int RAND_ITEMS  = 350;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic [srca_pkg::SEQ_W-1:0]    seq;
		logic [srca_pkg::LEN_W-1:0]    len;
		logic [srca_pkg::HANDLE_W-1:0] handle;
		logic [srca_pkg::STAMP_W-1:0]  stamp;
		bit                            typed;    // ack number below is typed in by hand
		logic [srca_pkg::SEQ_W-1:0]    ack_pos;
	} seg_req_t;

	typedef struct {
		logic [srca_pkg::KIND_W-1:0]   kind;
		logic [srca_pkg::SEQ_W-1:0]    pos;
		logic [srca_pkg::LEN_W-1:0]    len;
		logic [srca_pkg::HANDLE_W-1:0] handle;
		logic [srca_pkg::STAMP_W-1:0]  stamp;
		logic                          last;
	} rx_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [srca_pkg::SEQ_W-1:0]    seq_number;
	logic [srca_pkg::LEN_W-1:0]    data_length;
	logic [srca_pkg::HANDLE_W-1:0] payload_handle;
	logic [srca_pkg::STAMP_W-1:0]  tx_stamp;
	logic                          strobe;
	logic [srca_pkg::KIND_W-1:0]   result_kind;
	logic [srca_pkg::SEQ_W-1:0]    position;
	logic [srca_pkg::LEN_W-1:0]    released_length;
	logic [srca_pkg::HANDLE_W-1:0] released_handle;
	logic [srca_pkg::STAMP_W-1:0]  echo_stamp;
	logic                          last_of_run;

	segment_reorder_cumulative_ack_core #(
		.BUFFER_SLOTS      (NUM_SLOTS),
		.MAX_SEGMENT_BYTES (MAX_BYTES)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.seq_number      (seq_number),
		.data_length     (data_length),
		.payload_handle  (payload_handle),
		.tx_stamp        (tx_stamp),
		.strobe          (strobe),
		.result_kind     (result_kind),
		.position        (position),
		.released_length (released_length),
		.released_handle (released_handle),
		.echo_stamp      (echo_stamp),
		.last_of_run     (last_of_run)
	);

	// Predictor state: next in-order byte, end-of-stream flag, parked segments.
	logic [srca_pkg::SEQ_W-1:0]    next_rx_seq;
	bit                            stream_closed;
	bit                            park_valid [NUM_SLOTS];
	logic [srca_pkg::SEQ_W-1:0]    park_seq   [NUM_SLOTS];
	logic [srca_pkg::LEN_W-1:0]    park_len   [NUM_SLOTS];
	logic [srca_pkg::HANDLE_W-1:0] park_handle[NUM_SLOTS];

	rx_result_t expected_results[$];
	int         err_cnt = 0;
	int         tbl_err_cnt;
	int         idle_cycles;
	bit         gaps_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Saturating byte advance.
	function automatic logic [srca_pkg::SEQ_W-1:0] seq_after(
		input logic [srca_pkg::SEQ_W-1:0] s, input logic [srca_pkg::LEN_W-1:0] l);
		logic [srca_pkg::SEQ_W:0] sum;
		sum = {1'b0, s} + {{(srca_pkg::SEQ_W+1-srca_pkg::LEN_W){1'b0}}, l};
		return sum[srca_pkg::SEQ_W] ? srca_pkg::SEQ_MAX : sum[srca_pkg::SEQ_W-1:0];
	endfunction

	function automatic rx_result_t mk_result(input logic [srca_pkg::KIND_W-1:0] k,
		input logic [srca_pkg::SEQ_W-1:0] p, input logic [srca_pkg::LEN_W-1:0] l,
		input logic [srca_pkg::HANDLE_W-1:0] h, input logic [srca_pkg::STAMP_W-1:0] s,
		input logic lst);
		rx_result_t r;
		r.kind = k; r.pos = p; r.len = l; r.handle = h; r.stamp = s; r.last = lst;
		return r;
	endfunction

	// Work out the results of one accepted request and queue them in order.
	task automatic reorder_predict(input seg_req_t r);
		bit dup;
		bit found;
		if (stream_closed)
			return;
		if (r.len == 0) begin
			stream_closed = 1'b1;
			expected_results.push_back(mk_result(srca_pkg::KIND_END, next_rx_seq,
				'0, '0, '0, 1'b1));
			return;
		end
		if (r.len <= MAX_BYTES) begin
			if (r.seq > next_rx_seq) begin
				// park in the lowest free slot unless the offset is already held
				dup = 1'b0;
				foreach (park_valid[i])
					if (park_valid[i] && park_seq[i] == r.seq)
						dup = 1'b1;
				if (!dup) begin
					foreach (park_valid[i]) begin
						if (!park_valid[i]) begin
							park_valid[i]  = 1'b1;
							park_seq[i]    = r.seq;
							park_len[i]    = r.len;
							park_handle[i] = r.handle;
							break;
						end
					end
				end
			end else if (r.seq == next_rx_seq) begin
				expected_results.push_back(mk_result(srca_pkg::KIND_REL, r.seq, r.len,
					r.handle, '0, 1'b0));
				next_rx_seq = seq_after(r.seq, r.len);
				// rescan until a full pass finds nothing; later slots see the new value
				do begin
					found = 1'b0;
					foreach (park_valid[i]) begin
						if (park_valid[i] && park_seq[i] == next_rx_seq) begin
							expected_results.push_back(mk_result(srca_pkg::KIND_REL,
								park_seq[i], park_len[i], park_handle[i], '0, 1'b0));
							next_rx_seq   = seq_after(park_seq[i], park_len[i]);
							park_valid[i] = 1'b0;
							found         = 1'b1;
						end
					end
				end while (found);
			end
		end
		expected_results.push_back(mk_result(srca_pkg::KIND_ACK, next_rx_seq, '0, '0,
			r.stamp, 1'b1));
	endtask

	// Drive one request at the falling edge and hold it until taken.
	task automatic send_request(input seg_req_t r);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		start          <= 1'b1;
		seq_number     <= r.seq;
		data_length    <= r.len;
		payload_handle <= r.handle;
		tx_stamp       <= r.stamp;
		do @(posedge clk); while (busy);
		reorder_predict(r);
		if (r.typed && expected_results.size() > 0
			&& expected_results[$].pos !== r.ack_pos) begin
			$error("position expected %0d actual %0d", r.ack_pos,
				expected_results[$].pos);
			tbl_err_cnt++;
		end
		@(negedge clk);
	endtask

	// Compare each strobed result with the oldest expectation.
	always @(posedge clk) begin
		rx_result_t e;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result kind %0d position %0d", result_kind, position);
				err_cnt++;
			end else begin
				e = expected_results.pop_front();
				if (result_kind !== e.kind) begin
					$error("result_kind expected %0d actual %0d", e.kind, result_kind);
					err_cnt++;
				end
				if (position !== e.pos) begin
					$error("position expected %0d actual %0d", e.pos, position);
					err_cnt++;
				end
				if (released_length !== e.len) begin
					$error("released_length expected %0d actual %0d", e.len, released_length);
					err_cnt++;
				end
				if (released_handle !== e.handle) begin
					$error("released_handle expected %0d actual %0d", e.handle,
						released_handle);
					err_cnt++;
				end
				if (echo_stamp !== e.stamp) begin
					$error("echo_stamp expected %0d actual %0d", e.stamp, echo_stamp);
					err_cnt++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run expected %0d actual %0d", e.last, last_of_run);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: count cycles where no request is taken and no result leaves.
	always @(posedge clk) begin
		if ((start && !busy) || strobe || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		seg_req_t directed_tbl[14];
		seg_req_t burst[$];
		seg_req_t round[$];
		seg_req_t r;
		seg_req_t t;
		int       n_sent;
		int       far_cnt;
		int       k;
		int       j;
		logic [srca_pkg::SEQ_W-1:0] base;

		// Hold every input low and the block in reset.
		arst_n         = 1'b0;
		start          = 1'b0;
		seq_number     = '0;
		data_length    = '0;
		payload_handle = '0;
		tx_stamp       = '0;
		tbl_err_cnt    = 0;
		gaps_on        = 1'b1;
		next_rx_seq    = '0;
		stream_closed  = 1'b0;
		foreach (park_valid[i])
			park_valid[i] = 1'b0;

		// seq, len, handle, stamp, typed, ack
		directed_tbl = '{
			'{31'd5,          11'd10,   16'h1234, 32'h0000_0001, 1'b1, 31'd0},   // park ahead
			'{31'd0,          11'd5,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, 31'd15},  // release + chain
			'{31'd0,          11'd3,    16'h0001, 32'h0000_0002, 1'b1, 31'd15},  // stale
			'{31'd15,         11'd2047, 16'h0002, 32'h0000_0003, 1'b1, 31'd15},  // oversized
			'{31'd15,         11'd1457, 16'h0003, 32'h0000_0004, 1'b1, 31'd15},  // just over max
			'{31'h7FFF_FFFF,  11'd1456, 16'h0000, 32'h8000_0000, 1'b1, 31'd15},  // far ahead
			'{31'h7FFF_FFFF,  11'd7,    16'h0004, 32'h0000_0005, 1'b1, 31'd15},  // duplicate
			'{31'd40,         11'd1,    16'h0040, 32'h0000_0006, 1'b1, 31'd15},
			'{31'd30,         11'd10,   16'h0030, 32'h0000_0007, 1'b1, 31'd15},
			'{31'd20,         11'd10,   16'h0020, 32'h0000_0008, 1'b1, 31'd15},
			'{31'd15,         11'd5,    16'h0015, 32'h0000_0009, 1'b1, 31'd41},  // long chain
			'{31'd41,         11'd1456, 16'h5555, 32'hAAAA_AAAA, 1'b1, 31'd1497},
			'{31'd1497,       11'd1,    16'h0000, 32'h0000_0000, 1'b1, 31'd1498},
			'{31'd1499,       11'd1,    16'hAAAA, 32'h5555_5555, 1'b0, 31'd0}    // leave a hole
		};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_tbl[i])
			send_request(directed_tbl[i]);

		// Random bursts: a contiguous run from the next in-order byte, sent
		// shuffled; resend what is still missing until the run is through.
		// next_rx_seq can never climb near 2^31 in a run, so saturation of
		// the ack number stays out of reach here.
		n_sent  = 0;
		far_cnt = 1;
		while (n_sent < RAND_ITEMS) begin
			// start a new run once the ack has moved past the last start offset
			if (burst.size() == 0 || next_rx_seq > burst[$].seq) begin
				burst.delete();
				base = next_rx_seq;
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 8);
				for (int b = 0; b < k; b++) begin
					r.seq     = base;
					r.len     = srca_pkg::LEN_W'($urandom_range(1, MAX_BYTES));
					r.handle  = srca_pkg::HANDLE_W'($urandom);
					r.stamp   = $urandom;
					r.typed   = 1'b0;
					r.ack_pos = '0;
					burst.push_back(r);
					base = seq_after(base, r.len);
				end
			end
			round.delete();
			foreach (burst[i])
				if (burst[i].seq >= next_rx_seq)
					round.push_back(burst[i]);
			// add noise: duplicates, stale, oversized, far ahead
			repeat ($urandom_range(0, 3)) begin
				r = burst[$urandom_range(0, burst.size() - 1)];
				r.stamp = $urandom;
				case ($urandom_range(0, 3))
					0: r.handle = srca_pkg::HANDLE_W'($urandom);
					1: if (next_rx_seq > 0)
						r.seq = srca_pkg::SEQ_W'($urandom_range(0, next_rx_seq - 1));
					2: r.len = srca_pkg::LEN_W'($urandom_range(MAX_BYTES + 1, 2047));
					default: if (far_cnt < 3) begin
						r.seq = srca_pkg::SEQ_W'(32'h4000_0000 | $urandom);
						far_cnt++;
					end
				endcase
				round.push_back(r);
			end
			for (int i = round.size() - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = round[i]; round[i] = round[j]; round[j] = t;
			end
			foreach (round[i]) begin
				// run flat out over the last stretch
				if (n_sent > RAND_ITEMS * 85 / 100)
					gaps_on = 1'b0;
				send_request(round[i]);
				n_sent++;
			end
		end

		// End of stream, then a few requests that must be dropped silently.
		r.seq = srca_pkg::SEQ_W'($urandom); r.len = '0;
		r.handle = srca_pkg::HANDLE_W'($urandom); r.stamp = $urandom;
		r.typed = 1'b0;
		send_request(r);
		repeat (3) begin
			r.seq = next_rx_seq; r.len = srca_pkg::LEN_W'($urandom_range(1, MAX_BYTES));
			send_request(r);
		end
		start <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0 && tbl_err_cnt == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
